/* src/mkcd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the multi-key click event detector
// no dependencies; imported by every module of the block
package mkcd_pkg;

    // field widths
    localparam int LEVEL_W   = 8;
    localparam int INDEX_W   = 3;
    localparam int FLAG_W    = 7;
    localparam int PERIOD_W  = 8;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 2;

    // key count limits
    localparam int NUM_KEYS_DEF = 8;

    // commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT        = 2'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd20;
    localparam logic [TIMER_W-1:0]  LONG_PRESS_RST    = 16'd2000;
    localparam logic [TIMER_W-1:0]  DOUBLE_GAP_RST    = 16'd200;
    localparam logic [TIMER_W-1:0]  REPEAT_RST        = 16'd100;

    // flag bit positions
    localparam int FL_HOLD   = 0;
    localparam int FL_DOWN   = 1;
    localparam int FL_UP     = 2;
    localparam int FL_SINGLE = 3;
    localparam int FL_DOUBLE = 4;
    localparam int FL_LONG   = 5;
    localparam int FL_REPEAT = 6;

    // a mask of exactly hold tests without clearing
    localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 7'b000_0001;

    // timeout registers as seen by every key
    typedef struct packed {
        logic [TIMER_W-1:0] long_press;
        logic [TIMER_W-1:0] double_gap;
        logic [TIMER_W-1:0] repeat_gap;
    } t_timeouts;

    // per-key control for the beat being processed
    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              level;
        logic              clear;
        logic [FLAG_W-1:0] mask;
    } t_key_ctrl;

endpackage

/* src/multi_key_click_event_detector_top.sv */
`timescale 1ns / 1ps
// Multi-key click event detector, top level.
// Input channel (i_in_valid / o_in_stall) carries one command per beat: a
// time tick with the pressed levels of all keys, or a check of one key's
// flags against a mask. Every input beat yields exactly one output beat on
// (o_out_valid / i_out_stall): flag_hit and key_flags for a check, zeros for
// a tick. A check that hits clears the masked flags unless the mask is
// exactly HOLD.
// The beat enters the input register at the accepting edge, then the result
// register that drives o_out_valid, fed by the per-key update. One beat is
// accepted every cycle while o_in_stall is low; all keys update in parallel in
// a single pass. On a receiver stall the result register holds, an empty input
// register takes one more beat, then o_in_stall rises until the result leaves.
// The config port (i_cfg_valid / o_cfg_ready) is always ready; write it only
// while the block is idle. Synchronous reset clears all key state, the
// prescaler and both pipeline registers, and loads the default timeouts.
// depends on mkcd_pkg, mkcd_prescale, mkcd_key
module multi_key_click_event_detector_top #(
    parameter int NUM_KEYS = mkcd_pkg::NUM_KEYS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [mkcd_pkg::LEVEL_W-1:0]   i_pressed_levels,
    input  logic [mkcd_pkg::INDEX_W-1:0]   i_key_index,
    input  logic [mkcd_pkg::FLAG_W-1:0]    i_flag_mask,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_flag_hit,
    output logic [mkcd_pkg::FLAG_W-1:0]    o_key_flags,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mkcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkcd_pkg::TIMER_W-1:0]   i_cfg_data
);
    import mkcd_pkg::*;

    // config registers
    logic [PERIOD_W-1:0] r_sample_period;
    t_timeouts           r_tmo;

    // input register
    logic                r_in_valid;
    logic                r_in_cmd;
    logic [LEVEL_W-1:0]  r_in_levels;
    logic [INDEX_W-1:0]  r_in_idx;
    logic [FLAG_W-1:0]   r_in_mask;

    // result register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [FLAG_W-1:0]   r_out_flags;

    logic                w_advance;
    logic                w_do_tick;
    logic                w_do_check;
    logic                w_sample;
    logic                w_key_ok;
    logic [FLAG_W-1:0]   w_sel_flags;
    logic                w_hit;
    logic                w_clear;
    logic [FLAG_W-1:0]   w_key_flags [NUM_KEYS];
    t_key_ctrl           w_ctrl [NUM_KEYS];

    // handshakes
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_flag_hit  = r_out_hit;
    assign o_key_flags = r_out_flags;

    // the beat in the input register is processed when it moves on
    assign w_do_tick  = r_in_valid && w_advance && (r_in_cmd == CMD_TICK);
    assign w_do_check = r_in_valid && w_advance && (r_in_cmd == CMD_CHECK);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period  <= SAMPLE_PERIOD_RST;
            r_tmo.long_press <= LONG_PRESS_RST;
            r_tmo.double_gap <= DOUBLE_GAP_RST;
            r_tmo.repeat_gap <= REPEAT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SAMPLE_PERIOD: r_sample_period  <= i_cfg_data[PERIOD_W-1:0];
                REG_LONG_PRESS:    r_tmo.long_press <= i_cfg_data;
                REG_DOUBLE_GAP:    r_tmo.double_gap <= i_cfg_data;
                REG_REPEAT:        r_tmo.repeat_gap <= i_cfg_data;
                default:           r_tmo.repeat_gap <= r_tmo.repeat_gap;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_cmd    <= i_command;
            r_in_levels <= i_pressed_levels;
            r_in_idx    <= i_key_index;
            r_in_mask   <= i_flag_mask;
        end
    end

    // prescaler
    mkcd_prescale u_prescale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_do_tick),
        .i_period (r_sample_period),
        .o_sample (w_sample)
    );

    // flag word of the checked key; keys past the index range read as absent
    always_comb begin
        w_sel_flags = '0;
        w_key_ok    = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if ((k < (1 << INDEX_W)) && (INDEX_W'(k) == r_in_idx)) begin
                w_sel_flags = w_key_flags[k];
                w_key_ok    = 1'b1;
            end
        end
        w_hit   = w_key_ok && ((w_sel_flags & r_in_mask) != '0);
        w_clear = w_do_check && w_hit && (r_in_mask != MASK_HOLD_ONLY);
    end

    // per-key slices
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
        always_comb begin
            w_ctrl[g].tick   = w_do_tick;
            w_ctrl[g].sample = w_sample;
            w_ctrl[g].level  = (g < LEVEL_W) ? r_in_levels[g % LEVEL_W] : 1'b0;
            w_ctrl[g].clear  = w_clear && (g < (1 << INDEX_W))
                               && (INDEX_W'(g) == r_in_idx);
            w_ctrl[g].mask   = r_in_mask;
        end

        mkcd_key u_key (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_tmo   (r_tmo),
            .o_flags (w_key_flags[g])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (r_in_cmd == CMD_CHECK) begin
                r_out_hit   <= w_hit;
                r_out_flags <= w_sel_flags;
            end else begin
                r_out_hit   <= 1'b0;
                r_out_flags <= '0;
            end
        end
    end

endmodule

/* src/mkcd_prescale.sv */
`timescale 1ns / 1ps
// tick prescaler: raises a sample strobe once every sample_period ticks
// depends on mkcd_pkg
module mkcd_prescale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [mkcd_pkg::PERIOD_W-1:0] i_period,
    output logic                          o_sample
);
    import mkcd_pkg::*;

    logic [PERIOD_W-1:0] r_count;
    logic [PERIOD_W-1:0] n_count;
    logic [PERIOD_W-1:0] w_inc;

    // increment first, then compare; wraps through zero on period 0
    always_comb begin
        w_inc    = r_count + 1'b1;
        o_sample = i_tick && (w_inc == i_period);
        n_count  = r_count;
        if (i_tick) begin
            n_count = o_sample ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

/* src/mkcd_key.sv */
`timescale 1ns / 1ps
// one key: level history, click mode machine, countdown timer and flag word
// depends on mkcd_pkg
module mkcd_key (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mkcd_pkg::t_key_ctrl         i_ctrl,
    input  mkcd_pkg::t_timeouts         i_tmo,
    output logic [mkcd_pkg::FLAG_W-1:0] o_flags
);
    import mkcd_pkg::*;

    // click modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PRESSED = 3'd1;
    localparam logic [2:0] MODE_WAIT    = 3'd2;
    localparam logic [2:0] MODE_SECOND  = 3'd3;
    localparam logic [2:0] MODE_LONG    = 3'd4;

    logic               r_level;
    logic               n_level;
    logic [2:0]         r_mode;
    logic [2:0]         n_mode;
    logic [TIMER_W-1:0] r_cd;
    logic [TIMER_W-1:0] n_cd;
    logic [FLAG_W-1:0]  r_flags;
    logic [FLAG_W-1:0]  n_flags;
    logic [TIMER_W-1:0] w_cd_dec;
    logic               w_cd_zero;
    logic               w_now;

    assign o_flags = r_flags;
    assign w_now   = i_ctrl.level;

    // countdown steps before the sample sees it
    always_comb begin
        w_cd_dec  = (r_cd != '0) ? (r_cd - 1'b1) : r_cd;
        w_cd_zero = (w_cd_dec == '0);
    end

    // next state for a tick, a sample or a clear
    always_comb begin
        n_level = r_level;
        n_mode  = r_mode;
        n_cd    = r_cd;
        n_flags = r_flags;
        if (i_ctrl.tick) begin
            n_cd = w_cd_dec;
            if (i_ctrl.sample) begin
                n_level          = w_now;
                n_flags[FL_HOLD] = w_now;
                if (!r_level && w_now) begin
                    n_flags[FL_DOWN] = 1'b1;
                end
                if (r_level && !w_now) begin
                    n_flags[FL_UP] = 1'b1;
                end
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (w_now) begin
                            n_flags[FL_DOWN] = 1'b1;
                            n_cd             = i_tmo.long_press;
                            n_mode           = MODE_PRESSED;
                        end
                    end
                    MODE_PRESSED: begin
                        if (!w_now) begin
                            n_cd   = i_tmo.double_gap;
                            n_mode = MODE_WAIT;
                        end else if (w_cd_zero) begin
                            n_cd             = i_tmo.repeat_gap;
                            n_flags[FL_LONG] = 1'b1;
                            n_mode           = MODE_LONG;
                        end
                    end
                    MODE_WAIT: begin
                        if (w_now) begin
                            n_flags[FL_DOUBLE] = 1'b1;
                            n_mode             = MODE_SECOND;
                        end else if (w_cd_zero) begin
                            n_flags[FL_SINGLE] = 1'b1;
                            n_mode             = MODE_IDLE;
                        end
                    end
                    MODE_SECOND: begin
                        if (!w_now) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_LONG: begin
                        if (!w_now) begin
                            n_mode = MODE_IDLE;
                        end else if (w_cd_zero) begin
                            n_cd               = i_tmo.repeat_gap;
                            n_flags[FL_REPEAT] = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end else if (i_ctrl.clear) begin
            n_flags = r_flags & ~i_ctrl.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_cd    <= '0;
            r_flags <= '0;
        end else begin
            r_level <= n_level;
            r_mode  <= n_mode;
            r_cd    <= n_cd;
            r_flags <= n_flags;
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for the multi-key click event detector top level
// depends on mkcd_pkg and the detector RTL; predicts every result beat in a scoreboard class

import mkcd_pkg::*;

// click machine modes of one key
typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PRESSED,
    MODE_GAP_WAIT,
    MODE_SECOND,
    MODE_LONG_RUN
} t_click_mode;

// one result beat as the block should send it
typedef struct packed {
    logic              hit;
    logic [FLAG_W-1:0] flags;
} t_flag_report;

class click_scoreboard;
    // register copies
    bit [PERIOD_W-1:0] period;
    bit [TIMER_W-1:0]  long_ticks;
    bit [TIMER_W-1:0]  gap_ticks;
    bit [TIMER_W-1:0]  rep_ticks;
    // key state
    bit [PERIOD_W-1:0]     prescale;
    bit [NUM_KEYS_DEF-1:0] level_seen;
    t_click_mode           mode [NUM_KEYS_DEF];
    bit [TIMER_W-1:0]      timer [NUM_KEYS_DEF];
    bit [FLAG_W-1:0]       flags [NUM_KEYS_DEF];
    // reports still owed by the block
    t_flag_report          owed_reports [$];
    int                    fault_count;

    function new();
        period     = SAMPLE_PERIOD_RST;
        long_ticks = LONG_PRESS_RST;
        gap_ticks  = DOUBLE_GAP_RST;
        rep_ticks  = REPEAT_RST;
        prescale   = '0;
        level_seen = '0;
        fault_count = 0;
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            mode[k]  = MODE_IDLE;
            timer[k] = '0;
            flags[k] = '0;
        end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] data);
        case (idx)
            REG_SAMPLE_PERIOD: period     = data[PERIOD_W-1:0];
            REG_LONG_PRESS:    long_ticks = data;
            REG_DOUBLE_GAP:    gap_ticks  = data;
            REG_REPEAT:        rep_ticks  = data;
            default: ;
        endcase
    endfunction

    // one sample of one key: level flags, then the click machine
    function void sample_key(int k, bit now);
        bit              was;
        bit [FLAG_W-1:0] f;
        was = level_seen[k];
        f = flags[k];
        level_seen[k] = now;
        f[FL_HOLD] = now;
        if (!was && now) f[FL_DOWN] = 1'b1;
        if (was && !now) f[FL_UP] = 1'b1;
        case (mode[k])
            MODE_IDLE: begin
                if (now) begin
                    f[FL_DOWN] = 1'b1;
                    timer[k] = long_ticks;
                    mode[k] = MODE_PRESSED;
                end
            end
            MODE_PRESSED: begin
                if (!now) begin
                    timer[k] = gap_ticks;
                    mode[k] = MODE_GAP_WAIT;
                end else if (timer[k] == 0) begin
                    timer[k] = rep_ticks;
                    f[FL_LONG] = 1'b1;
                    mode[k] = MODE_LONG_RUN;
                end
            end
            MODE_GAP_WAIT: begin
                if (now) begin
                    f[FL_DOUBLE] = 1'b1;
                    mode[k] = MODE_SECOND;
                end else if (timer[k] == 0) begin
                    f[FL_SINGLE] = 1'b1;
                    mode[k] = MODE_IDLE;
                end
            end
            MODE_SECOND: begin
                if (!now) mode[k] = MODE_IDLE;
            end
            MODE_LONG_RUN: begin
                if (!now) begin
                    mode[k] = MODE_IDLE;
                end else if (timer[k] == 0) begin
                    timer[k] = rep_ticks;
                    f[FL_REPEAT] = 1'b1;
                end
            end
            default: ;
        endcase
        flags[k] = f;
    endfunction

    // accepted input beat: advance the key state and queue the owed report
    function void note_command(logic cmd, logic [LEVEL_W-1:0] levels,
                               logic [INDEX_W-1:0] idx, logic [FLAG_W-1:0] mask);
        t_flag_report r;
        r = '0;
        if (cmd == CMD_TICK) begin
            for (int k = 0; k < NUM_KEYS_DEF; k++)
                if (timer[k] != 0) timer[k] = timer[k] - 1'b1;
            prescale = prescale + 1'b1;
            if (prescale == period) begin
                prescale = '0;
                for (int k = 0; k < NUM_KEYS_DEF; k++) sample_key(k, levels[k]);
            end
        end else begin
            // eight keys, so every index names a present key
            r.flags = flags[idx];
            r.hit = (flags[idx] & mask) != 0;
            if (r.hit && mask != MASK_HOLD_ONLY) flags[idx] = flags[idx] & ~mask;
        end
        owed_reports.push_back(r);
    endfunction

    function void check_response(logic hit, logic [FLAG_W-1:0] got_flags);
        t_flag_report want;
        if (owed_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: result beat with none owed: hit %0b flags %02h",
                         $time, hit, got_flags);
            return;
        end
        want = owed_reports.pop_front();
        if (hit !== want.hit || got_flags !== want.flags) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: result mismatch: expected hit %0b flags %02h, got hit %0b flags %02h",
                         $time, want.hit, want.flags, hit, got_flags);
        end
    endfunction

    function int owed();
        return owed_reports.size();
    endfunction
endclass

module testbench;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_command;
    logic [LEVEL_W-1:0]   i_pressed_levels;
    logic [INDEX_W-1:0]   i_key_index;
    logic [FLAG_W-1:0]    i_flag_mask;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_flag_hit;
    logic [FLAG_W-1:0]    o_key_flags;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TIMER_W-1:0]   i_cfg_data;

    click_scoreboard board;
    int              burst_left = 0;
    t_stall_style    stall_style = STALL_NONE;
    int              stall_span = 0;
    int              stall_phase = 0;

    multi_key_click_event_detector_top #(
        .NUM_KEYS(NUM_KEYS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_pressed_levels(i_pressed_levels),
        .i_key_index     (i_key_index),
        .i_flag_mask     (i_flag_mask),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_flag_hit      (o_flag_hit),
        .o_key_flags     (o_key_flags),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // watch all three channels at the edge where beats move
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && !i_out_stall) board.check_response(o_flag_hit, o_key_flags);
            if (i_in_valid && !o_in_stall)
                board.note_command(i_command, i_pressed_levels, i_key_index, i_flag_mask);
            if (i_cfg_valid && o_cfg_ready) board.set_register(i_cfg_index, i_cfg_data);
        end
    end

    // receiver stall pattern, switching style after each random span
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 150);
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_phase <= (stall_phase + 1) % 5;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 99) < 75);
            STALL_PERIODIC: i_out_stall <= (stall_phase < 2);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // sender bursts: after a random run of beats, drop valid for a random pause
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [LEVEL_W-1:0] levels,
                             input logic [INDEX_W-1:0] idx, input logic [FLAG_W-1:0] mask);
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_pressed_levels <= levels;
        i_key_index <= idx;
        i_flag_mask <= mask;
        do @(posedge i_clk); while (o_in_stall);
        pace_sender();
    endtask

    // hold off the sender until every owed report has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.owed() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [PERIOD_W-1:0] period, input logic [TIMER_W-1:0] long_t,
                             input logic [TIMER_W-1:0] gap_t, input logic [TIMER_W-1:0] rep_t);
        drain_results();
        cfg_beat(REG_SAMPLE_PERIOD, TIMER_W'(period));
        cfg_beat(REG_LONG_PRESS, long_t);
        cfg_beat(REG_DOUBLE_GAP, gap_t);
        cfg_beat(REG_REPEAT, rep_t);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // keys press and release at their own random rates, with checks mixed in
    task automatic run_phase(input int n_items, input int check_pct, input int max_odds);
        int                 toggle_odds [NUM_KEYS_DEF];
        logic [LEVEL_W-1:0] levels;
        logic [FLAG_W-1:0]  mask;
        levels = '0;
        foreach (toggle_odds[k]) toggle_odds[k] = $urandom_range(2, max_odds);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < check_pct) begin
                case ($urandom_range(0, 5))
                    0: mask = '0;
                    1: mask = MASK_HOLD_ONLY;
                    2: mask = '1;
                    3, 4: begin
                        mask = '0;
                        mask[$urandom_range(FL_DOWN, FL_REPEAT)] = 1'b1;
                    end
                    default: mask = FLAG_W'($urandom);
                endcase
                send_beat(CMD_CHECK, LEVEL_W'($urandom),
                          INDEX_W'($urandom_range(0, NUM_KEYS_DEF - 1)), mask);
            end else begin
                // mostly clean presses, now and then an arbitrary level pattern
                if ($urandom_range(0, 99) < 4) begin
                    levels = LEVEL_W'($urandom);
                end else begin
                    foreach (toggle_odds[k])
                        if ($urandom_range(0, toggle_odds[k] - 1) == 0) levels[k] = ~levels[k];
                end
                send_beat(CMD_TICK, levels, INDEX_W'($urandom), FLAG_W'($urandom));
            end
        end
    endtask

    initial begin
        board = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_command <= CMD_TICK;
        i_pressed_levels <= '0;
        i_key_index <= '0;
        i_flag_mask <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_SAMPLE_PERIOD;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty and full masks on clean keys, one sample with all keys
        // pressed at the reset period, then hold-only, full and single-flag checks
        send_beat(CMD_CHECK, 8'h00, 3'd0, 7'h00);
        send_beat(CMD_CHECK, 8'hFF, 3'd7, 7'h7F);
        for (int n = 0; n < SAMPLE_PERIOD_RST; n++)
            send_beat(CMD_TICK, (n == SAMPLE_PERIOD_RST - 1) ? 8'hFF : 8'h00, 3'd7, 7'h7F);
        send_beat(CMD_CHECK, 8'h00, 3'd0, MASK_HOLD_ONLY);
        send_beat(CMD_CHECK, 8'h00, 3'd0, 7'h7F);
        send_beat(CMD_CHECK, 8'hFF, 3'd7, 7'(1 << FL_DOWN));

        // zero timeouts at the fastest sampling
        configure(8'd1, 16'd0, 16'd0, 16'd0);
        run_phase(150, 30, 6);
        // largest period and timeouts
        configure(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(320, 10, 64);
        // period zero samples once per 256 ticks
        configure(8'd0, 16'd3, 16'd2, 16'd1);
        run_phase(300, 10, 64);
        // period lowered under the running count wraps the prescaler first
        configure(8'd2, 16'd5, 16'd3, 16'd2);
        run_phase(450, 20, 20);
        repeat (4) begin
            configure(PERIOD_W'($urandom_range(1, 4)), TIMER_W'($urandom_range(0, 16)),
                      TIMER_W'($urandom_range(0, 8)), TIMER_W'($urandom_range(0, 6)));
            run_phase(90, 25, 30);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (board.fault_count == 0 && board.owed() == 0) begin
            $display("TB_OK");
        end else begin
            if (board.owed() != 0) $display("results never delivered: %0d", board.owed());
            $display("TB_ERROR");
        end
        $finish;
    end

    // run time guard
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
